@@ sv/rvde_pkg.sv @@
// ----------------------------------------------------------------------------
// rvde_pkg
// shared types and constants for the rv32i decode/execute unit
// ----------------------------------------------------------------------------
package rvde_pkg;

  localparam int unsigned RegisterCount = 32;
  localparam int unsigned RegIdxW = $clog2(RegisterCount);

  localparam logic [31:0] HaltWord = 32'h0FF0_0513;

  typedef enum logic [6:0] {
    OP_LOAD   = 7'd3,
    OP_IMM    = 7'd19,
    OP_AUIPC  = 7'd23,
    OP_STORE  = 7'd35,
    OP_REG    = 7'd51,
    OP_LUI    = 7'd55,
    OP_BRANCH = 7'd99,
    OP_JALR   = 7'd103,
    OP_JAL    = 7'd111
  } opcode_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_op_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_e;

  localparam logic FuncExec = 1'b0;
  localparam logic FuncLoadRet = 1'b1;

endpackage

@@ sv/rv32i_decode_execute.sv @@
// ----------------------------------------------------------------------------
// rv32i_decode_execute
// rv32i execute unit with register file, branch/jump and load/store requests
// ----------------------------------------------------------------------------
// One word per cycle is sustained while the output is not stalled. An accepted
// word reads rs1/rs2 from a register file ram with registered read data; the
// word then sits in an execute stage, where forwarding from the write just made
// covers back to back dependences, and its result goes to an output register.
// Reset clears the per-entry valid bits of the register file at once, so no
// clearing pass is needed; an entry not yet written reads zero. A load-return
// word writes the pending load's destination.
module rv32i_decode_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [31:0] instruction_word_i,
  input  logic [31:0] program_counter_i,
  input  logic [31:0] load_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_pc_o,
  output logic [1:0]  mem_op_o,
  output logic [1:0]  access_size_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] store_value_o,
  output logic [4:0]  dest_index_o,
  output logic [31:0] dest_value_o,
  output logic        halted_o,
  output logic [7:0]  exit_code_o,
  output logic        bad_opcode_o
);

  localparam int unsigned IW = rvde_pkg::RegIdxW;
  localparam int unsigned RC = rvde_pkg::RegisterCount;

  // stage and output control
  logic ex_valid_q;
  logic ex_func_q;
  logic [31:0] ex_inst_q, ex_pc_q, ex_ld_q;
  logic out_valid_q;
  logic advance, accept;

  assign advance = ~out_valid_q | out_ready_i;
  assign in_ready_o = advance | ~ex_valid_q;
  assign accept = in_valid_i & in_ready_o;
  logic ex_fire;
  assign ex_fire = ex_valid_q & advance;

  // register file ram and valid bits
  logic          wr_en;
  logic [4:0]    wr_idx;
  logic [31:0]   wr_val;
  logic [RC-1:0] rf_vld_q;
  logic [31:0]   ram_a, ram_b;
  logic [4:0]    ra_idx, rb_idx, rx_idx;
  logic          ra_v_q, rb_v_q, rx_v_q;
  logic [31:0]   a0_q;

  assign ra_idx = instruction_word_i[19:15];
  assign rb_idx = instruction_word_i[24:20];

  rvde_ram #(.Width(32), .Depth(RC)) u_rf (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_idx[IW-1:0]),
    .wdata_i   (wr_val),
    .re_i      (accept),
    .raddr_a_i (ra_idx[IW-1:0]),
    .raddr_b_i (rb_idx[IW-1:0]),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // a0 kept in a shadow register for the halt exit code
  function automatic logic idx_ok(input logic [4:0] idx);
    return (idx != 5'd0) && ({27'd0, idx} < RC);
  endfunction

  // read-side qualifiers: valid bit and same-cycle write bypass
  logic          byp_a_q, byp_b_q;
  logic [31:0]   byp_val_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_v_q <= 1'b0;
      rb_v_q <= 1'b0;
      byp_a_q <= 1'b0;
      byp_b_q <= 1'b0;
    end else if (accept) begin
      ra_v_q <= idx_ok(ra_idx) && rf_vld_q[ra_idx[IW-1:0]];
      rb_v_q <= idx_ok(rb_idx) && rf_vld_q[rb_idx[IW-1:0]];
      byp_a_q <= wr_en && (wr_idx == ra_idx) && idx_ok(ra_idx);
      byp_b_q <= wr_en && (wr_idx == rb_idx) && idx_ok(rb_idx);
    end
  end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byp_val_q <= wr_val;
    end
  end
  assign rx_idx = 5'd10;
  assign rx_v_q = 1'b1;

  logic [31:0] a, b;
  assign a = byp_a_q ? byp_val_q : (ra_v_q ? ram_a : 32'd0);
  assign b = byp_b_q ? byp_val_q : (rb_v_q ? ram_b : 32'd0);

  // execute stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else if (accept) begin
      ex_valid_q <= 1'b1;
    end else if (ex_fire) begin
      ex_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_func_q <= func_i;
      ex_inst_q <= instruction_word_i;
      ex_pc_q   <= program_counter_i;
      ex_ld_q   <= load_data_i;
    end
  end

  // pending load
  logic       pl_valid_q, pl_valid_d;
  logic [4:0] pl_dest_q, pl_dest_d;
  logic [2:0] pl_kind_q, pl_kind_d;

  // decode and execute
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic        b30;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, opb, alu_y, pc4;
  logic        alt, take;
  logic [31:0] r_npc, r_addr, r_store, r_dval, t;
  logic [1:0]  r_mop, r_size;
  logic [4:0]  r_didx;
  logic        r_halt, r_bad, wr_t;
  logic [7:0]  r_exit;
  logic [31:0] ld;

  assign op  = ex_inst_q[6:0];
  assign f3  = ex_inst_q[14:12];
  assign rd  = ex_inst_q[11:7];
  assign b30 = ex_inst_q[30];
  assign pc4 = ex_pc_q + 32'd4;
  assign imm_i = {{20{ex_inst_q[31]}}, ex_inst_q[31:20]};
  assign imm_s = {{20{ex_inst_q[31]}}, ex_inst_q[31:25], ex_inst_q[11:7]};
  assign imm_b = {{19{ex_inst_q[31]}}, ex_inst_q[31], ex_inst_q[7], ex_inst_q[30:25],
                  ex_inst_q[11:8], 1'b0};
  assign imm_j = {{11{ex_inst_q[31]}}, ex_inst_q[31], ex_inst_q[19:12], ex_inst_q[20],
                  ex_inst_q[30:21], 1'b0};
  assign imm_u = {ex_inst_q[31:12], 12'd0};

  always_comb begin
    opb = b;
    alt = b30 && ((f3 == 3'd0) || (f3 == 3'd5));
    if (op == rvde_pkg::OP_IMM) begin
      opb = ((f3 == 3'd1) || (f3 == 3'd5)) ? {27'd0, imm_i[4:0]} : imm_i;
      alt = b30 && (f3 == 3'd5);
    end
    case (f3)
      3'd0: alu_y = alt ? a - opb : a + opb;
      3'd1: alu_y = a << opb[4:0];
      3'd2: alu_y = {31'd0, $signed(a) < $signed(opb)};
      3'd3: alu_y = {31'd0, a < opb};
      3'd4: alu_y = a ^ opb;
      3'd5: alu_y = alt ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
      3'd6: alu_y = a | opb;
      default: alu_y = a & opb;
    endcase
    case (f3)
      3'd0: take = a == b;
      3'd1: take = a != b;
      3'd4: take = $signed(a) < $signed(b);
      3'd5: take = $signed(a) >= $signed(b);
      3'd6: take = a < b;
      3'd7: take = a >= b;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    r_npc = 32'd0; r_mop = rvde_pkg::MEM_NONE; r_size = rvde_pkg::SIZE_BYTE;
    r_addr = 32'd0; r_store = 32'd0; r_didx = 5'd0; r_dval = 32'd0;
    r_halt = 1'b0; r_exit = 8'd0; r_bad = 1'b0;
    t = 32'd0; wr_t = 1'b0;
    pl_valid_d = pl_valid_q; pl_dest_d = pl_dest_q; pl_kind_d = pl_kind_q;
    ld = ex_ld_q;
    if (ex_func_q == rvde_pkg::FuncLoadRet) begin
      if (pl_valid_q) begin
        if (pl_kind_q[1:0] == 2'd0) begin
          ld = pl_kind_q[2] ? {24'd0, ex_ld_q[7:0]} : {{24{ex_ld_q[7]}}, ex_ld_q[7:0]};
        end else if (pl_kind_q[1:0] == 2'd1) begin
          ld = pl_kind_q[2] ? {16'd0, ex_ld_q[15:0]} : {{16{ex_ld_q[15]}}, ex_ld_q[15:0]};
        end
        pl_valid_d = 1'b0;
        if (idx_ok(pl_dest_q)) begin
          r_didx = pl_dest_q;
          r_dval = ld;
        end
      end
    end else if (ex_inst_q == rvde_pkg::HaltWord) begin
      r_npc = ex_pc_q;
      r_halt = 1'b1;
      r_exit = a0_q[7:0];
    end else begin
      r_npc = pc4;
      unique case (op)
        rvde_pkg::OP_REG, rvde_pkg::OP_IMM: begin
          t = alu_y; wr_t = 1'b1;
        end
        rvde_pkg::OP_JALR: begin
          r_npc = (a + imm_i) & ~32'd1; t = pc4; wr_t = 1'b1;
        end
        rvde_pkg::OP_JAL: begin
          r_npc = ex_pc_q + imm_j; t = pc4; wr_t = 1'b1;
        end
        rvde_pkg::OP_LUI: begin
          t = imm_u; wr_t = 1'b1;
        end
        rvde_pkg::OP_AUIPC: begin
          t = ex_pc_q + imm_u; wr_t = 1'b1;
        end
        rvde_pkg::OP_BRANCH: begin
          if (take) r_npc = ex_pc_q + imm_b;
        end
        rvde_pkg::OP_LOAD: begin
          r_mop = rvde_pkg::MEM_LOAD;
          r_size = (f3[1:0] == 2'd3) ? rvde_pkg::SIZE_WORD : f3[1:0];
          r_addr = a + imm_i;
          pl_valid_d = 1'b1; pl_dest_d = rd; pl_kind_d = f3;
        end
        rvde_pkg::OP_STORE: begin
          if (f3 <= 3'd2) begin
            r_mop = rvde_pkg::MEM_STORE;
            r_size = f3[1:0];
            r_addr = a + imm_s;
            r_store = b;
          end
        end
        default: r_bad = 1'b1;
      endcase
      if (wr_t && idx_ok(rd)) begin
        r_didx = rd;
        r_dval = t;
      end
    end
  end

  // register file write
  assign wr_en  = ex_fire && (r_didx != 5'd0);
  assign wr_idx = r_didx;
  assign wr_val = r_dval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q   <= '0;
      a0_q       <= 32'd0;
      pl_valid_q <= 1'b0;
      pl_dest_q  <= 5'd0;
      pl_kind_q  <= 3'd0;
    end else if (ex_fire) begin
      pl_valid_q <= pl_valid_d;
      pl_dest_q  <= pl_dest_d;
      pl_kind_q  <= pl_kind_d;
      if (wr_en) begin
        rf_vld_q[wr_idx[IW-1:0]] <= 1'b1;
        if (wr_idx == rx_idx && rx_v_q) a0_q <= wr_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= ex_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      next_pc_o     <= r_npc;
      mem_op_o      <= r_mop;
      access_size_o <= r_size;
      mem_address_o <= r_addr;
      store_value_o <= r_store;
      dest_index_o  <= r_didx;
      dest_value_o  <= r_dval;
      halted_o      <= r_halt;
      exit_code_o   <= r_exit;
      bad_opcode_o  <= r_bad;
    end
  end
  assign out_valid_o = out_valid_q;

endmodule

@@ sv/rvde_ram.sv @@
// ----------------------------------------------------------------------------
// rvde_ram
// generic single-write dual-read ram with registered read data
// ----------------------------------------------------------------------------
module rvde_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

@@ sim/rv32i_decode_execute_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_decode_execute_checker
// watches both channels, runs its own copy of the rv32i execute behavior on
// each accepted word and compares every result word field by field
// ----------------------------------------------------------------------------
module rv32i_decode_execute_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        func_i,
  input  logic [31:0] instruction_word_i,
  input  logic [31:0] program_counter_i,
  input  logic [31:0] load_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] next_pc_i,
  input  logic [1:0]  mem_op_i,
  input  logic [1:0]  access_size_i,
  input  logic [31:0] mem_address_i,
  input  logic [31:0] store_value_i,
  input  logic [4:0]  dest_index_i,
  input  logic [31:0] dest_value_i,
  input  logic        halted_i,
  input  logic [7:0]  exit_code_i,
  input  logic        bad_opcode_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  mem_op;
    logic [1:0]  access_size;
    logic [31:0] mem_address;
    logic [31:0] store_value;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        halted;
    logic [7:0]  exit_code;
    logic        bad_opcode;
  } exec_result_t;

  logic [31:0]  regs [32];
  logic [4:0]   ld_dest;
  logic [2:0]   ld_kind;
  logic         ld_busy;
  exec_result_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic [31:0] reg_read(logic [4:0] idx);
    if (idx == 0 || idx >= rvde_pkg::RegisterCount) return 32'd0;
    return regs[idx];
  endfunction

  function automatic logic [4:0] reg_write(logic [4:0] idx, logic [31:0] v);
    if (idx == 0 || idx >= rvde_pkg::RegisterCount) return 5'd0;
    regs[idx] = v;
    return idx;
  endfunction

  function automatic logic [31:0] alu(logic [2:0] f3, logic alt, logic [31:0] a,
                                      logic [31:0] b);
    case (f3)
      3'd0: return alt ? a - b : a + b;
      3'd1: return a << b[4:0];
      3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      3'd3: return (a < b) ? 32'd1 : 32'd0;
      3'd4: return a ^ b;
      3'd5: return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: return a | b;
      default: return a & b;
    endcase
  endfunction

  // predict one result word and update the shadow state
  function automatic exec_result_t execute_word(logic fn, logic [31:0] inst,
                                                logic [31:0] pc, logic [31:0] ld);
    exec_result_t r;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] a, b, imm, t;
    logic        take;
    r = '0;
    if (fn == rvde_pkg::FuncLoadRet) begin
      if (ld_busy) begin
        t = ld;
        if (ld_kind[1:0] == 2'd0) t = ld_kind[2] ? {24'd0, ld[7:0]} : {{24{ld[7]}}, ld[7:0]};
        else if (ld_kind[1:0] == 2'd1)
          t = ld_kind[2] ? {16'd0, ld[15:0]} : {{16{ld[15]}}, ld[15:0]};
        r.dest_index = reg_write(ld_dest, t);
        r.dest_value = (r.dest_index != 0) ? t : 32'd0;
        ld_busy = 1'b0;
      end
      return r;
    end
    rd = inst[11:7];
    f3 = inst[14:12];
    a = reg_read(inst[19:15]);
    b = reg_read(inst[24:20]);
    r.next_pc = pc + 4;
    if (inst == rvde_pkg::HaltWord) begin
      r.next_pc = pc;
      r.halted = 1'b1;
      t = reg_read(5'd10);
      r.exit_code = t[7:0];
      return r;
    end
    t = '0;
    case (inst[6:0])
      rvde_pkg::OP_REG: rd = reg_write(rd, alu(f3, inst[30] && (f3 == 0 || f3 == 5), a, b));
      rvde_pkg::OP_IMM: begin
        imm = {{20{inst[31]}}, inst[31:20]};
        if (f3 == 1 || f3 == 5) imm = imm & 32'd31;
        rd = reg_write(rd, alu(f3, inst[30] && f3 == 5, a, imm));
      end
      rvde_pkg::OP_JALR: begin
        r.next_pc = (a + {{20{inst[31]}}, inst[31:20]}) & ~32'd1;
        rd = reg_write(rd, pc + 4);
      end
      rvde_pkg::OP_JAL: begin
        r.next_pc = pc + {{12{inst[31]}}, inst[19:12], inst[20], inst[30:21], 1'b0};
        rd = reg_write(rd, pc + 4);
      end
      rvde_pkg::OP_LUI: rd = reg_write(rd, {inst[31:12], 12'd0});
      rvde_pkg::OP_AUIPC: rd = reg_write(rd, pc + {inst[31:12], 12'd0});
      rvde_pkg::OP_BRANCH: begin
        imm = {{20{inst[31]}}, inst[7], inst[30:25], inst[11:8], 1'b0};
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = $signed(a) >= $signed(b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: take = 1'b0;
        endcase
        if (take) r.next_pc = pc + imm;
        rd = 0;
      end
      rvde_pkg::OP_LOAD: begin
        r.mem_op = rvde_pkg::MEM_LOAD;
        r.access_size = (f3[1:0] == 2'd3) ? rvde_pkg::SIZE_WORD : f3[1:0];
        r.mem_address = a + {{20{inst[31]}}, inst[31:20]};
        ld_dest = rd;
        ld_kind = f3;
        ld_busy = 1'b1;
        rd = 0;
      end
      rvde_pkg::OP_STORE: begin
        if (f3 <= 2) begin
          r.mem_op = rvde_pkg::MEM_STORE;
          r.access_size = f3[1:0];
          r.mem_address = a + {{20{inst[31]}}, inst[31:25], inst[11:7]};
          r.store_value = b;
        end
        rd = 0;
      end
      default: begin
        r.bad_opcode = 1'b1;
        rd = 0;
      end
    endcase
    r.dest_index = rd;
    r.dest_value = (rd != 0) ? regs[rd] : 32'd0;
    return r;
  endfunction

  // predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    exec_result_t got, exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) regs[i] = '0;
      ld_dest = '0;
      ld_kind = '0;
      ld_busy = 1'b0;
      errors_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(execute_word(func_i, instruction_word_i,
                                          program_counter_i, load_data_i));
      if (out_valid_i && out_ready_i) begin
        got = '{next_pc_i, mem_op_i, access_size_i, mem_address_i, store_value_i,
                dest_index_i, dest_value_i, halted_i, exit_code_i, bad_opcode_i};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected pc=%h op=%0d sz=%0d ad=%h sv=%h rd=%0d",
                     $time, exp_r.next_pc, exp_r.mem_op, exp_r.access_size,
                     exp_r.mem_address, exp_r.store_value, exp_r.dest_index);
            $display("    val=%h h=%b ec=%h bad=%b | actual pc=%h op=%0d sz=%0d ad=%h",
                     exp_r.dest_value, exp_r.halted, exp_r.exit_code, exp_r.bad_opcode,
                     got.next_pc, got.mem_op, got.access_size, got.mem_address);
            $display("    sv=%h rd=%0d val=%h h=%b ec=%h bad=%b", got.store_value,
                     got.dest_index, got.dest_value, got.halted, got.exit_code,
                     got.bad_opcode);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/rv32i_decode_execute_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_decode_execute_tb
// directed and random instruction streams with bursty input and output stalls
// ----------------------------------------------------------------------------
module rv32i_decode_execute_tb;

  logic        clk, rst_n;
  logic        in_valid, in_ready, func;
  logic [31:0] instr, pc, ld_data;
  logic        out_valid, out_ready;
  logic [31:0] next_pc, mem_address, store_value, dest_value;
  logic [1:0]  mem_op, access_size;
  logic [4:0]  dest_index;
  logic        halted, bad_opcode;
  logic [7:0]  exit_code;
  int          errors, pending;
  logic        hold_off;

  rv32i_decode_execute dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .instruction_word_i(instr), .program_counter_i(pc),
    .load_data_i(ld_data), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .next_pc_o(next_pc), .mem_op_o(mem_op), .access_size_o(access_size),
    .mem_address_o(mem_address), .store_value_o(store_value),
    .dest_index_o(dest_index), .dest_value_o(dest_value), .halted_o(halted),
    .exit_code_o(exit_code), .bad_opcode_o(bad_opcode)
  );

  rv32i_decode_execute_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .func_i(func), .instruction_word_i(instr), .program_counter_i(pc),
    .load_data_i(ld_data), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .next_pc_i(next_pc), .mem_op_i(mem_op), .access_size_i(access_size),
    .mem_address_i(mem_address), .store_value_i(store_value),
    .dest_index_i(dest_index), .dest_value_i(dest_value), .halted_i(halted),
    .exit_code_i(exit_code), .bad_opcode_i(bad_opcode),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[rv32i_decode_execute] ERROR");
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    out_ready = 1'b0;
    hold_off = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 9) < 6);
    end
  end

  int gap_left, burst_left;

  // offer one word, holding it until accepted; words in a burst follow back to back
  task automatic send_word(logic fn, logic [31:0] w, logic [31:0] p, logic [31:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      while (gap_left > 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        gap_left--;
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= fn;
    instr <= w;
    pc <= p;
    ld_data <= d;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [6:0]  ops [9];
    ops = '{rvde_pkg::OP_LOAD, rvde_pkg::OP_IMM, rvde_pkg::OP_AUIPC, rvde_pkg::OP_STORE,
            rvde_pkg::OP_REG, rvde_pkg::OP_LUI, rvde_pkg::OP_BRANCH, rvde_pkg::OP_JALR,
            rvde_pkg::OP_JAL};
    w = $urandom;
    // keep registers mostly in a small set so dependences are common
    if ($urandom_range(0, 1)) begin
      w[11:7] = 5'($urandom_range(0, 7));
      w[19:15] = 5'($urandom_range(0, 7));
      w[24:20] = 5'($urandom_range(0, 7));
    end
    if ($urandom_range(0, 19) != 0) w[6:0] = ops[$urandom_range(0, 8)];
    if ($urandom_range(0, 99) == 0) w = rvde_pkg::HaltWord;
    return w;
  endfunction

  initial begin
    logic [31:0] w;
    logic [31:0] dir_words [20];
    rst_n = 1'b0;
    in_valid = 1'b0;
    func = rvde_pkg::FuncExec;
    instr = '0;
    pc = '0;
    ld_data = '0;
    burst_left = 0;
    dir_words = '{
      32'h8000_0093,  // addi x1, x0, -2048
      32'h7FF0_0113,  // addi x2, x0, 2047
      32'hFFFF_F1B7,  // lui x3
      32'h4020_8233,  // sub x4
      32'h4011_D293,  // srai x5,x3,1
      32'hFE20_8EE3,  // beq back
      32'h0020_A333,  // slt
      32'h0020_B3B3,  // sltu
      32'h0011_3413,  // sltiu x8,x2,1
      32'h0020_A023,  // sw
      32'h0020_B023,  // unused store funct3
      32'h0000_A483,  // lw x9
      32'h0000_4503,  // lbu x10
      32'h0000_0003,  // lb x0
      32'h0000_E583,  // kind 6
      32'h0020_A063,  // unused branch funct3
      32'hFFDF_F6EF,  // jal x13 back
      32'h0011_0767,  // jalr x14
      32'hFFFF_FFFF,  // bad opcode
      rvde_pkg::HaltWord
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // load return with nothing pending
    send_word(rvde_pkg::FuncLoadRet, 32'h0, 32'h0, 32'hFFFF_FFFF);
    foreach (dir_words[i]) begin
      send_word(rvde_pkg::FuncExec, dir_words[i], 32'hFFFF_FFFC - i * 4, 32'h0);
      if (dir_words[i][6:0] == rvde_pkg::OP_LOAD)
        send_word(rvde_pkg::FuncLoadRet, 32'h0, 32'h0,
                  (i % 2) ? 32'h0000_8080 : 32'hFFFF_7F7F);
    end
    for (int n = 0; n < 1500; n++) begin
      if (n == 500) begin
        // long receiver hold-off while the sender keeps pushing
        hold_off = 1'b1;
        fork
          begin
            repeat (200) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (n == 1000) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      w = rand_instr();
      send_word(rvde_pkg::FuncExec, w, $urandom, 32'h0);
      if (w[6:0] == rvde_pkg::OP_LOAD && w != rvde_pkg::HaltWord
          && $urandom_range(0, 4) != 0)
        send_word(rvde_pkg::FuncLoadRet, $urandom, $urandom, $urandom);
      else if ($urandom_range(0, 30) == 0)
        send_word(rvde_pkg::FuncLoadRet, $urandom, $urandom, $urandom);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("[rv32i_decode_execute] OK");
    else $display("[rv32i_decode_execute] ERROR");
    $finish;
  end

endmodule
